/* src/ppu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared constants, stage type and color helpers for the palette pixel
// unpacker.
// ----------------------------------------------------------------------------
package ppu_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int WORD_W          = 32;
   localparam int COLOR_W         = 16;
   localparam int ADDR_W          = 9;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 3;
   localparam int MODE_W          = 3;

   // pixel modes
   localparam logic [MODE_W-1:0] MODE_PAL1 = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PAL2 = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PAL4 = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PAL8 = 3'd3;
   localparam logic [MODE_W-1:0] MODE_1555 = 3'd4;
   localparam logic [MODE_W-1:0] MODE_888  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_565  = 3'd6;
   localparam logic [MODE_W-1:0] MODE_444  = 3'd7;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_MODE        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEEP_COLOR_ORDER  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIG_ENDIAN_BYTES  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIG_ENDIAN_PIXELS = 2'd3;

   // one pixel on its way from the sequencer to the color stage
   typedef struct packed {
      logic               valid;
      logic               last;
      logic               pal;
      logic               conv1555;
      logic [COLOR_W-1:0] raw;
   } ppu_stage_type;

   function automatic logic [COLOR_W-1:0] from1555(input logic [COLOR_W-1:0] h);
      logic [COLOR_W-1:0] sum;
      sum = {1'b0, h[14:0]} + {1'b0, h[14:5], 5'b0} + {10'b0, h[15], 5'b0};
      return sum;
   endfunction

   function automatic logic [COLOR_W-1:0] from444(input logic [COLOR_W-1:0] h);
      return {h[11:8], 1'b0, h[7:4], 2'b0, h[3:0], 1'b0};
   endfunction

   function automatic logic [COLOR_W-1:0] rb_swap565(input logic [COLOR_W-1:0] h,
                                                     input logic keep);
      return keep ? h : {h[4:0], h[10:5], h[15:11]};
   endfunction

   function automatic logic [WORD_W-1:0] out565(input logic [COLOR_W-1:0] h);
      logic [WORD_W-1:0] x;
      x = {8'hFF, h[15:11], 3'b0, h[10:5], 2'b0, h[4:0], 3'b0};
      return x | ((x >> 5) & 32'h0004_0004) | ((x >> 6) & 32'h0003_0303);
   endfunction

endpackage

/* src/ppu_palette_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_palette_ram
// Palette store: one write port with byte lanes, one registered read port.
// ----------------------------------------------------------------------------
module ppu_palette_ram #(
   parameter int ENTRIES = ppu_pkg::PALETTE_ENTRIES,
   parameter int AW      = $clog2(ENTRIES)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [1:0]                  wr_lane,
   input  logic [AW-1:0]               wr_addr,
   input  logic [ppu_pkg::COLOR_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [ppu_pkg::COLOR_W-1:0] rd_data
);

   logic [ppu_pkg::COLOR_W-1:0] mem_ff [ENTRIES];
   logic [ppu_pkg::COLOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en && wr_lane[0]) begin
         mem_ff[wr_addr][7:0] <= wr_data[7:0];
      end
      if (wr_en && wr_lane[1]) begin
         mem_ff[wr_addr][15:8] <= wr_data[15:8];
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ppu_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_seq
// Pixel sequencer: walks one frame buffer word pixel by pixel, issues palette
// reads for indexed modes and packs direct colors into 16-bit form.
// ----------------------------------------------------------------------------
module ppu_seq #(
   parameter int AW = $clog2(ppu_pkg::PALETTE_ENTRIES)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic [ppu_pkg::WORD_W-1:0] word,
   input  logic [ppu_pkg::MODE_W-1:0] mode,
   input  logic                       be_bytes,
   input  logic                       be_pixels,
   output logic                       seq_busy,
   output logic                       rd_en,
   output logic [AW-1:0]              rd_addr,
   output ppu_pkg::ppu_stage_type     stage
);

   logic                       active_ff, active_in;
   logic [4:0]                 cnt_ff, cnt_in;
   logic [ppu_pkg::WORD_W-1:0] word_ff, word_in;
   ppu_pkg::ppu_stage_type     stage_ff, stage_in;

   logic        pal;
   logic [4:0]  last_cnt;
   logic        is_last;
   logic [5:0]  step;
   logic [4:0]  bitpos;
   logic [4:0]  bi;
   logic [4:0]  shift;
   logic [ppu_pkg::WORD_W-1:0] sel;
   logic [7:0]  mask;
   logic [ppu_pkg::WORD_W-1:0] rot;
   logic [ppu_pkg::COLOR_W-1:0] half;
   logic [ppu_pkg::COLOR_W-1:0] raw;

   always_comb begin
      pal      = 1'b0;
      last_cnt = 5'd1;
      mask     = 8'hFF;
      case (mode) inside
         [ppu_pkg::MODE_PAL1:ppu_pkg::MODE_PAL8]: begin
            pal      = 1'b1;
            last_cnt = 5'd31 >> mode[1:0];
         end
         ppu_pkg::MODE_888: begin
            last_cnt = 5'd0;
         end
         default: begin
            last_cnt = 5'd1;
         end
      endcase
      case (mode[1:0])
         2'd0:    mask = 8'h01;
         2'd1:    mask = 8'h03;
         2'd2:    mask = 8'h0F;
         default: mask = 8'hFF;
      endcase
   end

   assign is_last = active_ff && (cnt_ff == last_cnt);

   // bit position of the current index, counted down from the top
   assign step   = (6'({1'b0, cnt_ff}) + 6'd1) << mode[1:0];
   assign bitpos = 5'(6'd32 - step);
   assign bi     = (be_bytes ? 5'd0 : 5'd24) ^
                   (be_pixels ? 5'd0 : 5'(4'd8 - (4'd1 << mode[1:0])));
   assign shift  = bitpos ^ bi;
   assign sel    = word_ff >> shift;

   assign rd_en   = active_ff && pal;
   assign rd_addr = sel[AW-1:0] & mask[AW-1:0];

   assign rot  = be_bytes ? {word_ff[15:0], word_ff[31:16]} : word_ff;
   assign half = cnt_ff[0] ? rot[31:16] : rot[15:0];

   always_comb begin
      case (mode)
         ppu_pkg::MODE_888: raw = {word_ff[23:19], word_ff[15:10], word_ff[7:3]};
         ppu_pkg::MODE_444: raw = ppu_pkg::from444(half);
         default:           raw = half;
      endcase
   end

   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      word_in   = word_ff;
      if (load) begin
         active_in = 1'b1;
         cnt_in    = 5'd0;
         word_in   = word;
      end else if (active_ff) begin
         if (is_last) begin
            active_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 5'd1;
         end
      end
      stage_in.valid    = active_ff;
      stage_in.last     = is_last;
      stage_in.pal      = pal;
      stage_in.conv1555 = pal || (mode == ppu_pkg::MODE_1555);
      stage_in.raw      = raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= 5'd0;
         stage_ff  <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
         stage_ff  <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   // a new word can enter while the last pixel of this one issues
   assign seq_busy = active_ff && !is_last;
   assign stage    = stage_ff;

endmodule

/* src/ppu_color.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_color
// Color stage: picks palette or direct color, converts 1555, swaps red and
// blue unless keep_order is set, widens to ARGB8888 into the result register.
// ----------------------------------------------------------------------------
module ppu_color (
   input  logic                        clock,
   input  logic                        reset,
   input  ppu_pkg::ppu_stage_type      stage,
   input  logic [ppu_pkg::COLOR_W-1:0] pal_data,
   input  logic                        keep_order,
   output logic                        rsp_valid,
   output logic [ppu_pkg::WORD_W-1:0]  rsp_pixel_argb,
   output logic                        rsp_last_pixel
);

   logic                        valid_ff;
   logic [ppu_pkg::WORD_W-1:0]  argb_ff, argb_in;
   logic                        last_ff;
   logic [ppu_pkg::COLOR_W-1:0] src;
   logic [ppu_pkg::COLOR_W-1:0] c565;

   assign src     = stage.pal ? pal_data : stage.raw;
   assign c565    = stage.conv1555 ? ppu_pkg::from1555(src) : src;
   assign argb_in = ppu_pkg::out565(ppu_pkg::rb_swap565(c565, keep_order));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      argb_ff <= argb_in;
      last_ff <= stage.last;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_pixel_argb = argb_ff;
   assign rsp_last_pixel = last_ff;

endmodule

/* src/palette_pixel_unpacker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_pixel_unpacker
// Unpacks 32-bit frame buffer words into ARGB8888 pixels through a palette.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start while busy is low. req_func 0 writes one palette
//   byte (no result); req_func 1 hands in a frame buffer word.
//   Pixels leave on rsp_valid, one per cycle, each for exactly one cycle;
//   rsp_last_pixel marks the final pixel of a word. The receiver has no stall.
//   The first pixel of a taken word passes the sequencer stage register and
//   palette read, then the color stage result register, to the result ports.
//   Throughput: palette modes give 32, 16, 8 or 4 pixels per word at one
//   pixel per cycle through the single palette read port; 1555/565/444 give
//   two pixels, 888 one pixel. A palette write does not raise busy. busy
//   drops during the last pixel of a word, so the next command follows with
//   no gap. Registers are written on csr_valid (csr_ready is always high);
//   the user must write them only while idle; the block does not enforce it.
//   Reset: registers go to zero and a clearing pass zeroes all palette
//   entries, one entry per cycle, holding busy high meanwhile.
// ----------------------------------------------------------------------------
module palette_pixel_unpacker #(
   parameter int PALETTE_ENTRIES = ppu_pkg::PALETTE_ENTRIES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_func,
   input  logic [ppu_pkg::WORD_W-1:0]      req_pixel_word,
   input  logic [ppu_pkg::ADDR_W-1:0]      req_palette_address,
   input  logic [7:0]                      req_palette_byte,
   output logic                            rsp_valid,
   output logic [ppu_pkg::WORD_W-1:0]      rsp_pixel_argb,
   output logic                            rsp_last_pixel,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ppu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ppu_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int AW = $clog2(PALETTE_ENTRIES);

   logic [ppu_pkg::MODE_W-1:0] mode_ff;
   logic                       keep_ff;
   logic                       be_bytes_ff;
   logic                       be_pixels_ff;
   logic                       clear_ff;
   logic [AW-1:0]              clr_addr_ff;

   logic                        accept;
   logic                        seq_busy;
   logic                        wr_en;
   logic [1:0]                  wr_lane;
   logic [AW-1:0]               wr_addr;
   logic [ppu_pkg::COLOR_W-1:0] wr_data;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   logic [ppu_pkg::COLOR_W-1:0] rd_data;
   ppu_pkg::ppu_stage_type      stage;

   assign csr_ready = 1'b1;
   assign busy      = clear_ff || seq_busy;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= ppu_pkg::MODE_PAL1;
         keep_ff      <= 1'b0;
         be_bytes_ff  <= 1'b0;
         be_pixels_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ppu_pkg::CSR_PIXEL_MODE:        mode_ff      <= csr_data;
            ppu_pkg::CSR_KEEP_COLOR_ORDER:  keep_ff      <= csr_data[0];
            ppu_pkg::CSR_BIG_ENDIAN_BYTES:  be_bytes_ff  <= csr_data[0];
            ppu_pkg::CSR_BIG_ENDIAN_PIXELS: be_pixels_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // sweep the palette to zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clear_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(PALETTE_ENTRIES - 1)) begin
            clear_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      if (clear_ff) begin
         wr_en   = 1'b1;
         wr_lane = 2'b11;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = accept && !req_func;
         wr_lane = req_palette_address[0] ? 2'b10 : 2'b01;
         wr_addr = req_palette_address[AW:1];
         wr_data = {req_palette_byte, req_palette_byte};
      end
   end

   ppu_palette_ram #(
      .ENTRIES (PALETTE_ENTRIES),
      .AW      (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_lane (wr_lane),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ppu_seq #(
      .AW (AW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && req_func),
      .word      (req_pixel_word),
      .mode      (mode_ff),
      .be_bytes  (be_bytes_ff),
      .be_pixels (be_pixels_ff),
      .seq_busy  (seq_busy),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .stage     (stage)
   );

   ppu_color u_color (
      .clock          (clock),
      .reset          (reset),
      .stage          (stage),
      .pal_data       (rd_data),
      .keep_order     (keep_ff),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_argb (rsp_pixel_argb),
      .rsp_last_pixel (rsp_last_pixel)
   );

`ifndef SYNTHESIS
   // no pixel may come out while the palette is still being cleared
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !rsp_valid)
      else $error("pixel strobe during palette clear");

   // a taken data word brings its first pixel out on rsp_valid
   a_word_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func) |-> ##3 rsp_valid)
      else $error("missing first pixel after data word");

   // the last pixel issued by the sequencer leaves flagged as last
   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      (stage.valid && stage.last) |=> (rsp_valid && rsp_last_pixel))
      else $error("last pixel flag lost");

   // palette reads only happen for pixels that are in flight
   a_read_has_pixel: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> stage.valid && stage.pal)
      else $error("palette read without matching pixel");
`endif

endmodule
